[src/d2q9_bgk_collision_assert.svh]
// assertion macros for the d2q9 bgk collision block
// depends on nothing; included by modules that carry assertions
`ifndef D2Q9_BGK_COLLISION_ASSERT_SVH
`define D2Q9_BGK_COLLISION_ASSERT_SVH
`ifndef SYNTHESIS
`define D2Q_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define D2Q_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define D2Q_ASSERT_IMP(label, clk, rst, ante, cons)
`define D2Q_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[src/d2q_pkg.sv]
// shared types, constants and fixed point helpers for the d2q9 collision
// depends on nothing
package d2q_pkg;
   localparam int NDIR = 9;
   localparam int VAL_W = 24;
   localparam int INT_W = 32;
   localparam int OMEGA_W = 22;
   localparam int SPEED_W = 24;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_OMEGA = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED = 8'd1;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [INT_W-1:0] int_type;
   typedef val_type dist_type [NDIR];
   typedef int_type ivec_type [NDIR];

   // saturate a 66-bit value to 32 bits
   function automatic int_type sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return int_type'(32'sh7fffffff);
      else if (x < -66'sd2147483648) return int_type'(32'sh80000000);
      else return int_type'(x[31:0]);
   endfunction

   // halve with floor((x+1)/2)
   function automatic int_type halve(input int_type x);
      logic signed [32:0] t;
      t = 33'(x) + 33'sd1;
      return int_type'(t >>> 1);
   endfunction
endpackage

[src/d2q_if.sv]
// valid/ready channel interfaces for the d2q9 collision
// depends on d2q_pkg
interface d2q_req_if;
   logic valid;
   logic ready;
   d2q_pkg::val_type dist_rest, dist_east, dist_north, dist_west, dist_south;
   d2q_pkg::val_type dist_northeast, dist_northwest, dist_southwest, dist_southeast;
   d2q_pkg::val_type density, vel_x, vel_y;
   modport source (output valid, dist_rest, dist_east, dist_north, dist_west,
      dist_south, dist_northeast, dist_northwest, dist_southwest, dist_southeast,
      density, vel_x, vel_y, input ready);
   modport sink (input valid, dist_rest, dist_east, dist_north, dist_west,
      dist_south, dist_northeast, dist_northwest, dist_southwest, dist_southeast,
      density, vel_x, vel_y, output ready);
endinterface

interface d2q_rsp_if;
   logic valid;
   logic ready;
   d2q_pkg::val_type new_rest, new_east, new_north, new_west, new_south;
   d2q_pkg::val_type new_northeast, new_northwest, new_southwest, new_southeast;
   modport source (output valid, new_rest, new_east, new_north, new_west,
      new_south, new_northeast, new_northwest, new_southwest, new_southeast,
      input ready);
   modport sink (input valid, new_rest, new_east, new_north, new_west,
      new_south, new_northeast, new_northwest, new_southwest, new_southeast,
      output ready);
endinterface

interface d2q_csr_if;
   logic valid;
   logic ready;
   logic [d2q_pkg::CSR_IDX_W-1:0] index;
   logic [d2q_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/d2q_fmul.sv]
// fixed point multiply with round half up and 32-bit saturation
// depends on d2q_pkg
module d2q_fmul #(
   parameter int FRAC_BITS = 20
) (
   input  d2q_pkg::int_type a,
   input  d2q_pkg::int_type b,
   output d2q_pkg::int_type y
);
   logic signed [63:0] prod;
   logic signed [65:0] rnd;
   assign prod = a * b;
   assign rnd = (66'(prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign y = d2q_pkg::sat32(rnd);
endmodule

[src/d2q9_bgk_collision.sv]
// D2Q9 BGK collision, one node per cycle unless the output stalls.
// Channels: req (nine distributions, density, velocity), rsp (nine new
// distributions), csr (register writes: 0 omega, 1 speed factor).
// Throughput one transaction per cycle while the output is not stalled.
// Seven register stages, each holding at most one multiply level; the
// last stage is the output register.
// Stall: when the output register is full and rsp.ready is low the whole
// pipeline freezes in place, so req.ready falls only when the output
// register is full and not taken; nothing is lost or repeated.
// Reset: clears all valid bits, omega to 1.0 and speed factor to 3.0.
// Registers must be written only while the pipeline is empty.
// depends on d2q_pkg, d2q_if, d2q_fmul, d2q9_bgk_collision_assert.svh
`include "d2q9_bgk_collision_assert.svh"
module d2q9_bgk_collision #(
   parameter int FRAC_BITS = 20
) (
   input logic clock,
   input logic reset,
   d2q_req_if.sink req,
   d2q_rsp_if.source rsp,
   d2q_csr_if.sink csr
);
   localparam int NS = 7;
   typedef d2q_pkg::int_type word_type;
   localparam word_type ONE = word_type'(64'sd1 <<< FRAC_BITS);
   localparam word_type W0 =
      word_type'((64'sd4 * (64'sd2 <<< FRAC_BITS) + 64'sd9) / 64'sd18);
   localparam word_type W1 =
      word_type'((64'sd1 * (64'sd2 <<< FRAC_BITS) + 64'sd9) / 64'sd18);
   localparam word_type W2 =
      word_type'((64'sd1 * (64'sd2 <<< FRAC_BITS) + 64'sd36) / 64'sd72);

   logic [d2q_pkg::OMEGA_W-1:0] omega_ff;
   logic [d2q_pkg::SPEED_W-1:0] speed_ff;
   logic adv;
   logic [NS-1:0] vld_ff;
   word_type s_i, om_i;

   // register file
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff <= d2q_pkg::OMEGA_W'(64'd1 << FRAC_BITS);
         speed_ff <= d2q_pkg::SPEED_W'(64'd3 << FRAC_BITS);
      end else if (csr.valid) begin
         if (csr.index == d2q_pkg::REG_OMEGA) omega_ff <= csr.data[d2q_pkg::OMEGA_W-1:0];
         else if (csr.index == d2q_pkg::REG_SPEED)
            speed_ff <= csr.data[d2q_pkg::SPEED_W-1:0];
      end
   end
   assign s_i = word_type'({8'd0, speed_ff});
   assign om_i = word_type'({10'd0, omega_ff});

   // global enable: freeze when output full and not taken
   assign adv = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = adv;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], req.valid};
   end

   // stage 0: capture and form p
   d2q_pkg::ivec_type f0_ff, f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   d2q_pkg::ivec_type p0_ff, sp1_ff, sp2_ff, t22_ff, br3_ff, rb4_ff, d5_ff, d6_in;
   word_type rho0_ff, rho1_ff, rho2_ff, rho3_ff, ux0_ff, uy0_ff, u21_ff, t32_ff;
   d2q_pkg::ivec_type p0_in, sp1_in, sq2_in, rb4_in, fe5_in, md6_in;
   word_type ux, uy, uxx, uyy, u2_in, su2, t3_in;
   d2q_pkg::val_type fin [d2q_pkg::NDIR];
   logic signed [1:0] ex [d2q_pkg::NDIR];
   logic signed [1:0] ey [d2q_pkg::NDIR];
   assign ex = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
   assign ey = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
   assign fin = '{req.dist_rest, req.dist_east, req.dist_north, req.dist_west,
      req.dist_south, req.dist_northeast, req.dist_northwest, req.dist_southwest,
      req.dist_southeast};
   assign ux = word_type'(req.vel_x);
   assign uy = word_type'(req.vel_y);
   always_comb begin
      for (int k = 0; k < d2q_pkg::NDIR; k++)
         p0_in[k] = word_type'(ex[k]) * ux + word_type'(ey[k]) * uy;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < d2q_pkg::NDIR; k++) f0_ff[k] <= word_type'(fin[k]);
         p0_ff <= p0_in;
         rho0_ff <= word_type'(req.density);
         ux0_ff <= ux;
         uy0_ff <= uy;
      end
   end

   // stage 1: u2 and sp
   d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_uxx (.a(ux0_ff), .b(ux0_ff), .y(uxx));
   d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_uyy (.a(uy0_ff), .b(uy0_ff), .y(uyy));
   assign u2_in = d2q_pkg::sat32(66'(uxx) + 66'(uyy));
   // stage 2: sp*sp and s*u2
   d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_su2 (.a(s_i), .b(u21_ff), .y(su2));
   assign t3_in = d2q_pkg::halve(su2);
   // stage 1 sp, stage 2 squares, stage 4 rho*br, stage 5 weight, stage 6 omega
   for (genvar k = 0; k < d2q_pkg::NDIR; k++) begin : g_dir
      d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_sp (.a(s_i), .b(p0_ff[k]), .y(sp1_in[k]));
      d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_sq (.a(sp1_ff[k]), .b(sp1_ff[k]),
         .y(sq2_in[k]));
      d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_rb (.a(rho3_ff), .b(br3_ff[k]), .y(rb4_in[k]));
      d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_fe (.a(rb4_ff[k]),
         .b((k == 0) ? W0 : ((k < 5) ? W1 : W2)), .y(fe5_in[k]));
      d2q_fmul #(.FRAC_BITS(FRAC_BITS)) u_om (.a(om_i), .b(d5_ff[k]), .y(md6_in[k]));
   end
   // stage 3 bracket sum, stage 5 difference to equilibrium
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f0_ff; rho1_ff <= rho0_ff; u21_ff <= u2_in; sp1_ff <= sp1_in;
         f2_ff <= f1_ff; rho2_ff <= rho1_ff; t32_ff <= t3_in;
         sp2_ff <= sp1_ff;
         for (int k = 0; k < d2q_pkg::NDIR; k++) begin
            t22_ff[k] <= d2q_pkg::halve(sq2_in[k]);
            br3_ff[k] <= d2q_pkg::sat32(66'(ONE) + 66'(sp2_ff[k])
               + 66'(t22_ff[k]) - 66'(t32_ff));
            d5_ff[k] <= d2q_pkg::sat32(66'(fe5_in[k]) - 66'(f4_ff[k]));
         end
         f3_ff <= f2_ff; rho3_ff <= rho2_ff;
         f4_ff <= f3_ff; rb4_ff <= rb4_in;
         f5_ff <= f4_ff;
      end
   end

   // stage 6: final add and 24-bit saturation into output register
   d2q_pkg::dist_type out_ff;
   always_comb begin
      for (int k = 0; k < d2q_pkg::NDIR; k++) begin
         logic signed [33:0] r;
         r = 34'(f5_ff[k]) + 34'(md6_in[k]);
         if (r > 34'sd8388607) d6_in[k] = word_type'(32'sd8388607);
         else if (r < -34'sd8388608) d6_in[k] = word_type'(-32'sd8388608);
         else d6_in[k] = word_type'(r[31:0]);
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < d2q_pkg::NDIR; k++) out_ff[k] <= d6_in[k][23:0];
      end
   end
   assign rsp.valid = vld_ff[NS-1];
   assign rsp.new_rest = out_ff[0];
   assign rsp.new_east = out_ff[1];
   assign rsp.new_north = out_ff[2];
   assign rsp.new_west = out_ff[3];
   assign rsp.new_south = out_ff[4];
   assign rsp.new_northeast = out_ff[5];
   assign rsp.new_northwest = out_ff[6];
   assign rsp.new_southwest = out_ff[7];
   assign rsp.new_southeast = out_ff[8];

   `D2Q_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(out_ff[0]))
   `D2Q_ASSERT_IMP(a_rdy, clock, reset, !req.ready, rsp.valid && !rsp.ready)
   `D2Q_ASSERT_NXT(a_flow, clock, reset, req.valid && req.ready, vld_ff[0])
endmodule
